// File: rtl/core/pfr_pkg.sv
// Package for the paged framebuffer refresh stream: shared types, codes and defaults.
// Used by pfr_ctrl, pfr_dp, the top level and the port checker.
package pfr_pkg;

    // Default geometry.
    localparam int unsigned COLUMNS_DEF      = 132;
    localparam int unsigned PAGES_DEF        = 4;
    localparam int unsigned PIXEL_WIDTH_DEF  = 128;
    localparam int unsigned PIXEL_HEIGHT_DEF = 32;

    // Width of the linear index calculation: covers 4 pages of 255 columns.
    localparam int unsigned IDX_W = 10;

    // Register reset values.
    localparam logic [7:0] PAGE_OPC_RST = 8'd34;
    localparam logic [7:0] COL_OPC_RST  = 8'd33;

    // Register indexes.
    localparam logic CFG_PAGE_OPC = 1'b0;
    localparam logic CFG_COL_OPC  = 1'b1;

    // Slots of the per-page header.
    localparam int unsigned HDR_PAGE_CMD = 0;
    localparam int unsigned HDR_PAGE_LO  = 1;
    localparam int unsigned HDR_PAGE_HI  = 2;
    localparam int unsigned HDR_COL_CMD  = 3;
    localparam int unsigned HDR_COL_LO   = 4;
    localparam int unsigned HDR_COL_HI   = 5;
    localparam int unsigned HDR_LEN      = 6;

    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_REFRESH = 2'd2,
        OP_NEXT    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIXEL,
        ST_COPY,
        ST_SEND
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic copy_step;
        logic accept;
        logic pix_wr;
        logic send_ld;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic sweep_last;
        logic need_pixel;
        logic need_copy;
        logic need_send;
    } t_stat;

endpackage

// File: rtl/core/pfr_ctrl.sv
// Controller of the paged framebuffer refresh stream: sequencing state machine and handshakes.
// Depends on pfr_pkg; drives pfr_dp through pfr_pkg::t_cmd.
module pfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  pfr_pkg::t_stat i_stat,
    output pfr_pkg::t_cmd  o_cmd
);

    pfr_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;
    logic            accept;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == pfr_pkg::ST_IDLE) && i_in_valid && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfr_pkg::ST_CLEAR: begin
                if (i_stat.sweep_last) n_state = pfr_pkg::ST_IDLE;
            end
            pfr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_stat.need_pixel)     n_state = pfr_pkg::ST_PIXEL;
                    else if (i_stat.need_copy) n_state = pfr_pkg::ST_COPY;
                    else if (i_stat.need_send) n_state = pfr_pkg::ST_SEND;
                end
            end
            pfr_pkg::ST_PIXEL: n_state = pfr_pkg::ST_IDLE;
            pfr_pkg::ST_COPY: begin
                if (i_stat.sweep_last) n_state = pfr_pkg::ST_IDLE;
            end
            pfr_pkg::ST_SEND:  n_state = pfr_pkg::ST_IDLE;
            default:           n_state = pfr_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.clear_step = (r_state == pfr_pkg::ST_CLEAR);
        o_cmd.copy_step  = (r_state == pfr_pkg::ST_COPY);
        o_cmd.accept     = accept;
        o_cmd.pix_wr     = (r_state == pfr_pkg::ST_PIXEL);
        o_cmd.send_ld    = (r_state == pfr_pkg::ST_SEND);
        o_in_stall       = !((r_state == pfr_pkg::ST_IDLE) && out_free);
        o_out_valid      = r_out_valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((accept && !i_stat.need_send) || (r_state == pfr_pkg::ST_SEND)) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfr_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/core/pfr_dp.sv
// Datapath of the paged framebuffer refresh stream: draw and send stores, stream counters,
// opcode registers and result register. Depends on pfr_pkg; driven by pfr_ctrl.
module pfr_dp #(
    parameter int unsigned COLUMNS      = pfr_pkg::COLUMNS_DEF,
    parameter int unsigned PAGES        = pfr_pkg::PAGES_DEF,
    parameter int unsigned PIXEL_WIDTH  = pfr_pkg::PIXEL_WIDTH_DEF,
    parameter int unsigned PIXEL_HEIGHT = pfr_pkg::PIXEL_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_wdata,
    input  logic [1:0]     i_cmd,
    input  logic [7:0]     i_coord_x,
    input  logic [7:0]     i_coord_y,
    input  logic           i_lit,
    input  logic [1:0]     i_page_row,
    input  logic [7:0]     i_byte_value,
    input  pfr_pkg::t_cmd  i_ctl,
    output pfr_pkg::t_stat o_stat,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_out_byte,
    output logic           o_data_flag,
    output logic           o_last,
    output logic           o_rejected
);

    localparam int unsigned STORE_N = PAGES * COLUMNS;
    localparam int unsigned ADDR_W  = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam int unsigned POS_W   = $clog2(COLUMNS + pfr_pkg::HDR_LEN);
    localparam int unsigned IW      = pfr_pkg::IDX_W;

    logic [7:0] draw_mem [STORE_N];
    logic [7:0] send_mem [STORE_N];

    logic [7:0]        r_page_opc, r_col_opc;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_copy_v;
    logic [ADDR_W-1:0] r_copy_addr;
    logic [7:0]        r_draw_q, r_send_q;
    logic [ADDR_W-1:0] r_pix_addr;
    logic [7:0]        r_pix_mask;
    logic              r_pix_lit;
    logic              r_busy;
    logic [1:0]        r_spage;
    logic [POS_W-1:0]  r_spos;
    logic [ADDR_W-1:0] r_saddr;
    logic              r_pend_last;

    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_flag, r_last, r_rej;

    pfr_pkg::t_op op;
    logic              pix_ok, byte_ok;
    logic [ADDR_W-1:0] pix_addr, byte_addr;
    logic [7:0]        pix_mask;
    logic              pos_end, page_end, is_data;
    logic              sweep_last;

    logic              draw_we;
    logic [ADDR_W-1:0] draw_wa, draw_ra;
    logic [7:0]        draw_wd;

    logic [1:0] res_kind;
    logic [7:0] res_byte;
    logic       res_flag, res_last, res_rej;

    assign op = pfr_pkg::t_op'(i_cmd);

    // Range checks and linear addresses.
    assign pix_ok = (i_coord_x < 8'(PIXEL_WIDTH)) && (i_coord_y < 8'(PIXEL_HEIGHT))
                    && (i_coord_x < 8'(COLUMNS)) && (i_coord_y[7:3] < 5'(PAGES));
    assign byte_ok = (i_coord_x < 8'(COLUMNS)) && ({1'b0, i_page_row} < 3'(PAGES));
    assign pix_addr  = ADDR_W'(IW'(i_coord_y[4:3]) * IW'(COLUMNS) + IW'(i_coord_x));
    assign byte_addr = ADDR_W'(IW'(i_page_row) * IW'(COLUMNS) + IW'(i_coord_x));
    assign pix_mask  = 8'(1) << i_coord_y[2:0];

    assign sweep_last = (r_sweep == ADDR_W'(STORE_N - 1));
    assign pos_end    = (r_spos == POS_W'(COLUMNS + pfr_pkg::HDR_LEN - 1));
    assign page_end   = (r_spage == 2'(PAGES - 1));
    assign is_data    = (r_spos >= POS_W'(pfr_pkg::HDR_LEN));

    always_comb begin
        o_stat            = '0;
        o_stat.sweep_last = sweep_last;
        o_stat.need_pixel = (op == pfr_pkg::OP_PIXEL) && pix_ok;
        o_stat.need_copy  = (op == pfr_pkg::OP_REFRESH) && !r_busy;
        o_stat.need_send  = (op == pfr_pkg::OP_NEXT) && r_busy && is_data;
    end

    // Result of an item that completes at acceptance.
    always_comb begin
        res_kind = pfr_pkg::KIND_NONE;
        res_byte = 8'd0;
        res_flag = 1'b0;
        res_last = 1'b0;
        res_rej  = 1'b0;
        case (op)
            pfr_pkg::OP_PIXEL:   res_rej = !pix_ok;
            pfr_pkg::OP_BYTE:    res_rej = !byte_ok;
            pfr_pkg::OP_REFRESH: res_rej = r_busy;
            pfr_pkg::OP_NEXT: begin
                if (r_busy) begin
                    res_kind = pfr_pkg::KIND_CMD;
                    res_last = pos_end && page_end;
                    if (r_spos == POS_W'(pfr_pkg::HDR_PAGE_CMD)) begin
                        res_byte = r_page_opc;
                    end else if (r_spos == POS_W'(pfr_pkg::HDR_PAGE_LO) ||
                                 r_spos == POS_W'(pfr_pkg::HDR_PAGE_HI)) begin
                        res_byte = {6'd0, r_spage};
                    end else if (r_spos == POS_W'(pfr_pkg::HDR_COL_CMD)) begin
                        res_byte = r_col_opc;
                    end else if (r_spos == POS_W'(pfr_pkg::HDR_COL_HI)) begin
                        res_byte = 8'(COLUMNS);
                    end
                end
            end
            default: res_rej = 1'b0;
        endcase
    end

    // Draw store port selection.
    always_comb begin
        draw_we = 1'b0;
        draw_wa = r_sweep;
        draw_wd = 8'd0;
        if (i_ctl.clear_step) begin
            draw_we = 1'b1;
        end else if (i_ctl.pix_wr) begin
            draw_we = 1'b1;
            draw_wa = r_pix_addr;
            draw_wd = r_pix_lit ? (r_draw_q | r_pix_mask) : (r_draw_q & ~r_pix_mask);
        end else if (i_ctl.accept && (op == pfr_pkg::OP_BYTE) && byte_ok) begin
            draw_we = 1'b1;
            draw_wa = byte_addr;
            draw_wd = i_byte_value;
        end
        draw_ra = i_ctl.copy_step ? r_sweep : pix_addr;
    end

    always_ff @(posedge i_clk) begin
        if (draw_we) draw_mem[draw_wa] <= draw_wd;
        r_draw_q <= draw_mem[draw_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_copy_v) send_mem[r_copy_addr] <= r_draw_q;
        r_send_q <= send_mem[r_saddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_opc <= pfr_pkg::PAGE_OPC_RST;
            r_col_opc  <= pfr_pkg::COL_OPC_RST;
            r_sweep    <= '0;
            r_copy_v   <= 1'b0;
            r_busy     <= 1'b0;
            r_spage    <= '0;
            r_spos     <= '0;
            r_saddr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfr_pkg::CFG_PAGE_OPC: r_page_opc <= i_cfg_wdata;
                    pfr_pkg::CFG_COL_OPC:  r_col_opc  <= i_cfg_wdata;
                    default:               r_page_opc <= r_page_opc;
                endcase
            end
            if (i_ctl.clear_step || i_ctl.copy_step) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
            end
            r_copy_v <= i_ctl.copy_step;
            if (i_ctl.accept && (op == pfr_pkg::OP_REFRESH) && !r_busy) begin
                r_busy  <= 1'b1;
                r_spage <= '0;
                r_spos  <= '0;
                r_saddr <= '0;
            end else if (i_ctl.accept && (op == pfr_pkg::OP_NEXT) && r_busy) begin
                if (is_data) r_saddr <= r_saddr + 1'b1;
                if (pos_end) begin
                    r_spos <= '0;
                    if (page_end) begin
                        r_busy  <= 1'b0;
                        r_spage <= '0;
                    end else begin
                        r_spage <= r_spage + 1'b1;
                    end
                end else begin
                    r_spos <= r_spos + 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_copy_addr <= r_sweep;
        if (i_ctl.accept) begin
            r_pix_addr  <= pix_addr;
            r_pix_mask  <= pix_mask;
            r_pix_lit   <= i_lit;
            r_pend_last <= pos_end && page_end;
        end
        if (i_ctl.send_ld) begin
            r_kind <= pfr_pkg::KIND_DATA;
            r_byte <= r_send_q;
            r_flag <= 1'b1;
            r_last <= r_pend_last;
            r_rej  <= 1'b0;
        end else if (i_ctl.accept && !o_stat.need_send) begin
            r_kind <= res_kind;
            r_byte <= res_byte;
            r_flag <= res_flag;
            r_last <= res_last;
            r_rej  <= res_rej;
        end
    end

    assign o_kind      = r_kind;
    assign o_out_byte  = r_byte;
    assign o_data_flag = r_flag;
    assign o_last      = r_last;
    assign o_rejected  = r_rej;

endmodule

// File: rtl/core/paged_framebuffer_refresh_stream.sv
// Top level of the paged framebuffer refresh stream: joins controller and datapath.
// Depends on pfr_pkg, pfr_ctrl and pfr_dp.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_cmd i_coord_x i_coord_y i_lit i_page_row
//          |           |                         | i_byte_value
//  out     | from block| o_out_valid/i_out_stall | o_kind o_out_byte o_data_flag o_last o_rejected
//  cfg     | to block  | i_cfg_we                | i_cfg_idx i_cfg_wdata
//
// Byte writes, header bytes, rejected commands and idle next commands complete at acceptance;
// a pixel then passes through ST_PIXEL (read-modify-write on the draw store port) and a stream
// data byte through ST_SEND (the send store read is registered). An accepted start refresh runs
// ST_COPY: the copy walks the draw store one byte a cycle. After reset the draw store is cleared
// in ST_CLEAR, during which o_in_stall stays high. A stalled result holds in the output register;
// a new item is taken in the cycle that result transfers.
module paged_framebuffer_refresh_stream #(
    parameter int unsigned COLUMNS      = pfr_pkg::COLUMNS_DEF,
    parameter int unsigned PAGES        = pfr_pkg::PAGES_DEF,
    parameter int unsigned PIXEL_WIDTH  = pfr_pkg::PIXEL_WIDTH_DEF,
    parameter int unsigned PIXEL_HEIGHT = pfr_pkg::PIXEL_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    // command channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_coord_x,
    input  logic [7:0] i_coord_y,
    input  logic       i_lit,
    input  logic [1:0] i_page_row,
    input  logic [7:0] i_byte_value,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_data_flag,
    output logic       o_last,
    output logic       o_rejected
);

    pfr_pkg::t_cmd  ctl;
    pfr_pkg::t_stat stat;

    // Sequence clear, copy, pixel update and send read; own both handshakes.
    pfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (ctl)
    );

    // Stores, stream position and result register.
    pfr_dp #(
        .COLUMNS      (COLUMNS),
        .PAGES        (PAGES),
        .PIXEL_WIDTH  (PIXEL_WIDTH),
        .PIXEL_HEIGHT (PIXEL_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (i_cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_lit        (i_lit),
        .i_page_row   (i_page_row),
        .i_byte_value (i_byte_value),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_data_flag  (o_data_flag),
        .o_last       (o_last),
        .o_rejected   (o_rejected)
    );

endmodule

// File: rtl/core/pfr_chk.sv
// Port checker for the paged framebuffer refresh stream, bound to the top level.
// Depends on pfr_pkg for the result kind codes.
module pfr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_byte,
    input logic       o_data_flag,
    input logic       o_last,
    input logic       o_rejected
);

    a_flag_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_data_flag == (o_kind == pfr_pkg::KIND_DATA)))
        else $error("data flag disagrees with result kind");

    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == pfr_pkg::KIND_NONE) |-> (o_out_byte == 8'd0))
        else $error("byte present on a result without a byte");

    a_reject_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> (o_kind == pfr_pkg::KIND_NONE))
        else $error("rejected result carries a byte");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> (o_kind == pfr_pkg::KIND_DATA) && !o_rejected)
        else $error("last marked on a result that is not a data byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_kind))
        else $error("stalled result changed");

endmodule

bind paged_framebuffer_refresh_stream pfr_chk u_pfr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_out_byte  (o_out_byte),
    .o_data_flag (o_data_flag),
    .o_last      (o_last),
    .o_rejected  (o_rejected)
);
